// ===== hdl/i2cme_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// No dependencies.
`default_nettype none

package i2cme_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam int unsigned UNIT_W     = 8;
  localparam int unsigned PHASE_W    = 5;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned SUB_W      = 2;

  localparam logic [PHASE_W-1:0] COND_UNITS = PHASE_W'(4);
  localparam logic [PHASE_W-1:0] BYTE_UNITS = PHASE_W'(27);
  localparam logic [SLOT_W-1:0]  ACK_SLOT   = SLOT_W'(8);
  localparam logic [SUB_W-1:0]   SUB_SETUP  = SUB_W'(0);
  localparam logic [SUB_W-1:0]   SUB_SAMPLE = SUB_W'(2);
  localparam logic [UNIT_W-1:0]  UNIT_TICKS_RESET = UNIT_W'(6);

endpackage

`default_nettype wire

// ===== hdl/i2c_master_byte_engine_unit.sv =====
// I2C master byte engine: tick-driven START/STOP/WRITE/READ bit sequencer.
// Depends on i2cme_pkg.
`default_nettype none

// Each input beat is one tick of the bit timer and yields exactly one output
// beat; a beat is taken every cycle while the output register is free or
// drained. A tick with tuser set while idle starts a command on that tick.
// START and STOP last 4 units, WRITE and READ 27 units (8 data slots plus
// the ack slot, 3 units each), a unit being unit_ticks ticks (0 acts as 1).
// m_tlast marks the last tick of a command. unit_ticks is written through the
// cfg channel; the user must write it only while the engine is idle, as the
// engine itself does not enforce this.
module i2c_master_byte_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [1:0] mode, [9:2] tx_byte, [10] send_nack, [11] sda_in, [15:12] zero
  input  wire logic [15:0] s_tdata,
  // [0] cmd_valid
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] scl_out, [1] sda_release, [2] busy_res, [10:3] rx_byte,
  // [11] nack_seen, [15:12] zero
  output logic [15:0]      m_tdata,
  // done_res
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic [i2cme_pkg::UNIT_W-1:0]  unit_ticks;
  logic [i2cme_pkg::UNIT_W-1:0]  unit_timer, unit_timer_next;
  logic [i2cme_pkg::PHASE_W-1:0] phase_index, phase_index_next;
  logic [i2cme_pkg::SLOT_W-1:0]  slot, slot_next;
  logic [i2cme_pkg::SUB_W-1:0]   sub, sub_next;
  i2cme_pkg::cmd_t               active_cmd, active_cmd_next;
  logic                          busy, busy_next;
  logic [7:0]                    shift_reg, shift_reg_next;
  logic                          ack_to_send, ack_to_send_next;
  logic                          scl_level, scl_level_next;
  logic                          sda_level, sda_level_next;
  logic [7:0]                    received_byte, received_byte_next;
  logic                          nack_flag, nack_flag_next;
  logic                          scl_o, sda_o, busy_o, done_o;

  logic s_fire;
  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic                          load;
    logic                          wr;
    logic                          cond;
    logic                          lo;
    logic [i2cme_pkg::UNIT_W-1:0]  ut;
    logic [i2cme_pkg::UNIT_W:0]    tmr_inc;
    logic [i2cme_pkg::PHASE_W-1:0] total;
    logic [i2cme_pkg::PHASE_W-1:0] ph_inc;

    load = !busy && s_tuser;
    active_cmd_next    = load ? i2cme_pkg::cmd_t'(s_tdata[1:0]) : active_cmd;
    shift_reg_next     = load ? ((i2cme_pkg::cmd_t'(s_tdata[1:0]) == i2cme_pkg::CMD_WRITE)
                                 ? s_tdata[9:2] : 8'd0) : shift_reg;
    ack_to_send_next   = load ? s_tdata[10] : ack_to_send;
    busy_next          = busy || load;
    phase_index_next   = load ? '0 : phase_index;
    unit_timer_next    = load ? '0 : unit_timer;
    slot_next          = load ? '0 : slot;
    sub_next           = load ? '0 : sub;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    received_byte_next = received_byte;
    nack_flag_next     = nack_flag;
    busy_o = 1'b0;
    done_o = 1'b0;

    wr      = active_cmd_next == i2cme_pkg::CMD_WRITE;
    cond    = active_cmd_next == i2cme_pkg::CMD_START || active_cmd_next == i2cme_pkg::CMD_STOP;
    lo      = active_cmd_next == i2cme_pkg::CMD_STOP;
    ut      = (unit_ticks == '0) ? i2cme_pkg::UNIT_W'(1) : unit_ticks;
    total   = cond ? i2cme_pkg::COND_UNITS : i2cme_pkg::BYTE_UNITS;
    tmr_inc = {1'b0, unit_timer_next} + (i2cme_pkg::UNIT_W+1)'(1);
    ph_inc  = phase_index_next + i2cme_pkg::PHASE_W'(1);

    if (busy_next) begin
      busy_o = 1'b1;
      if (cond) begin
        unique case (phase_index_next)
          i2cme_pkg::PHASE_W'(1): sda_level_next = !lo;
          i2cme_pkg::PHASE_W'(2): begin
            scl_level_next = 1'b1;
            sda_level_next = !lo;
          end
          i2cme_pkg::PHASE_W'(3): begin
            scl_level_next = 1'b1;
            sda_level_next = lo;
          end
          default: ;
        endcase
      end else begin
        if (sub_next == i2cme_pkg::SUB_SETUP) begin
          scl_level_next = 1'b0;
          if (slot_next < i2cme_pkg::ACK_SLOT)
            sda_level_next = wr ? shift_reg_next[~slot_next[2:0]] : 1'b1;
          else
            sda_level_next = wr ? 1'b1 : ack_to_send_next;
        end else begin
          scl_level_next = 1'b1;
        end
        // one sample per slot, mid SCL-high
        if (sub_next == i2cme_pkg::SUB_SAMPLE && unit_timer_next == '0) begin
          if (slot_next < i2cme_pkg::ACK_SLOT) begin
            if (!wr) shift_reg_next = {shift_reg_next[6:0], s_tdata[11]};
          end else if (wr) begin
            nack_flag_next = s_tdata[11];
          end
        end
      end
      scl_o = scl_level_next;
      sda_o = sda_level_next;

      if (tmr_inc >= {1'b0, ut}) begin
        unit_timer_next  = '0;
        phase_index_next = ph_inc;
        if (sub_next == i2cme_pkg::SUB_SAMPLE) begin
          sub_next  = '0;
          slot_next = slot_next + i2cme_pkg::SLOT_W'(1);
        end else begin
          sub_next = sub_next + i2cme_pkg::SUB_W'(1);
        end
        if (ph_inc >= total) begin
          done_o           = 1'b1;
          busy_next        = 1'b0;
          phase_index_next = '0;
          slot_next        = '0;
          sub_next         = '0;
          if (active_cmd_next == i2cme_pkg::CMD_STOP) begin
            scl_level_next = 1'b1;
            sda_level_next = 1'b1;
          end else begin
            scl_level_next = 1'b0;
            if (active_cmd_next == i2cme_pkg::CMD_START) sda_level_next = 1'b0;
            if (active_cmd_next == i2cme_pkg::CMD_READ) received_byte_next = shift_reg_next;
          end
        end
      end else begin
        unit_timer_next = tmr_inc[i2cme_pkg::UNIT_W-1:0];
      end
    end else begin
      scl_o = scl_level;
      sda_o = sda_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks    <= i2cme_pkg::UNIT_TICKS_RESET;
      unit_timer    <= '0;
      phase_index   <= '0;
      slot          <= '0;
      sub           <= '0;
      active_cmd    <= i2cme_pkg::CMD_START;
      busy          <= 1'b0;
      shift_reg     <= '0;
      ack_to_send   <= 1'b0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      received_byte <= '0;
      nack_flag     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) unit_ticks <= cfg_data;
      if (s_fire) begin
        unit_timer    <= unit_timer_next;
        phase_index   <= phase_index_next;
        slot          <= slot_next;
        sub           <= sub_next;
        active_cmd    <= active_cmd_next;
        busy          <= busy_next;
        shift_reg     <= shift_reg_next;
        ack_to_send   <= ack_to_send_next;
        scl_level     <= scl_level_next;
        sda_level     <= sda_level_next;
        received_byte <= received_byte_next;
        nack_flag     <= nack_flag_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output beat register, payload not reset
  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {4'd0, nack_flag_next, received_byte_next, busy_o, sda_o, scl_o};
      m_tlast <= done_o;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (phase_index == '0 && unit_timer == '0 && slot == '0 && sub == '0))
    else $error("idle engine left with nonzero sequencing counters");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_index < i2cme_pkg::BYTE_UNITS && slot <= i2cme_pkg::ACK_SLOT)
    else $error("phase or slot counter out of range");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    s_fire && done_o |=> !busy && m_tvalid && m_tlast && m_tdata[2])
    else $error("finished command did not release busy");

  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    s_fire && done_o && active_cmd_next == i2cme_pkg::CMD_STOP |=> scl_level && sda_level)
    else $error("bus lines not released after STOP");

endmodule

`default_nettype wire

// ===== tb/i2c_master_byte_engine_unit_test.sv =====
// Self-checking testbench for i2c_master_byte_engine_unit: drives tick beats with
// START/STOP/WRITE/READ commands and checks every output beat against a predictor.
// Depends on i2cme_pkg and the i2c_master_byte_engine_unit RTL.
`default_nettype none

module i2c_master_byte_engine_unit_test;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int SDA_LOW     = 0;
  localparam int SDA_HIGH    = 1;
  localparam int SDA_RANDOM  = 2;

  typedef struct packed {
    logic       scl;
    logic       sda_rel;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       nack;
  } bus_tick_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  // predictor state
  logic [7:0]        eng_unit_ticks;
  logic [7:0]        eng_timer;
  logic [4:0]        eng_phase;
  i2cme_pkg::cmd_t   eng_cmd;
  logic              eng_busy;
  logic [7:0]        eng_shift;
  logic              eng_ack_bit;
  logic              eng_scl;
  logic              eng_sda;
  logic [7:0]        eng_rx;
  logic              eng_nack;

  bus_tick_t   bus_ticks_due[$];
  int          tick_mismatches;
  int          ticks_sent;
  int          src_gap_pct;
  int          sink_stall_pct;

  i2c_master_byte_engine_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void engine_reset();
    eng_unit_ticks = i2cme_pkg::UNIT_TICKS_RESET;
    eng_timer      = '0;
    eng_phase      = '0;
    eng_cmd        = i2cme_pkg::CMD_START;
    eng_busy       = 1'b0;
    eng_shift      = '0;
    eng_ack_bit    = 1'b0;
    eng_scl        = 1'b1;
    eng_sda        = 1'b1;
    eng_rx         = '0;
    eng_nack       = 1'b0;
  endfunction

  // Advances the engine by one tick and returns the line/status beat it emits.
  function automatic bus_tick_t advance_engine(logic cv, i2cme_pkg::cmd_t md,
                                               logic [7:0] tx, logic nk, logic sda_in);
    bus_tick_t  r;
    logic [7:0] ut;
    logic [4:0] total;
    logic [3:0] slot;
    logic [1:0] sub;
    logic       lo;
    logic       wr;
    r = '0;
    if (!eng_busy && cv) begin
      eng_cmd     = md;
      eng_shift   = (md == i2cme_pkg::CMD_WRITE) ? tx : 8'h00;
      eng_ack_bit = nk;
      eng_busy    = 1'b1;
      eng_phase   = '0;
      eng_timer   = '0;
    end
    r.scl     = eng_scl;
    r.sda_rel = eng_sda;
    if (eng_busy) begin
      ut    = (eng_unit_ticks == 8'd0) ? 8'd1 : eng_unit_ticks;
      total = (eng_cmd == i2cme_pkg::CMD_START || eng_cmd == i2cme_pkg::CMD_STOP)
              ? i2cme_pkg::COND_UNITS : i2cme_pkg::BYTE_UNITS;
      r.busy = 1'b1;
      if (eng_cmd == i2cme_pkg::CMD_START || eng_cmd == i2cme_pkg::CMD_STOP) begin
        lo = (eng_cmd == i2cme_pkg::CMD_STOP);
        case (eng_phase)
          5'd1: eng_sda = ~lo;
          5'd2: begin
            eng_scl = 1'b1;
            eng_sda = ~lo;
          end
          5'd3: begin
            eng_scl = 1'b1;
            eng_sda = lo;
          end
          default: ;
        endcase
      end else begin
        slot = 4'(eng_phase / 3);
        sub  = 2'(eng_phase % 3);
        wr   = (eng_cmd == i2cme_pkg::CMD_WRITE);
        if (sub == i2cme_pkg::SUB_SETUP) begin
          eng_scl = 1'b0;
          if (slot < i2cme_pkg::ACK_SLOT) eng_sda = wr ? eng_shift[7 - slot] : 1'b1;
          else eng_sda = wr ? 1'b1 : eng_ack_bit;
        end else begin
          eng_scl = 1'b1;
        end
        // SDA sampled once, mid SCL-high
        if (sub == i2cme_pkg::SUB_SAMPLE && eng_timer == 8'd0) begin
          if (slot < i2cme_pkg::ACK_SLOT) begin
            if (!wr) eng_shift = {eng_shift[6:0], sda_in};
          end else if (wr) begin
            eng_nack = sda_in;
          end
        end
      end
      r.scl     = eng_scl;
      r.sda_rel = eng_sda;
      eng_timer = eng_timer + 8'd1;
      if (eng_timer >= ut) begin
        eng_timer = '0;
        eng_phase = eng_phase + 5'd1;
        if (eng_phase >= total) begin
          r.done    = 1'b1;
          eng_busy  = 1'b0;
          eng_phase = '0;
          if (eng_cmd == i2cme_pkg::CMD_STOP) begin
            eng_scl = 1'b1;
            eng_sda = 1'b1;
          end else begin
            eng_scl = 1'b0;
            if (eng_cmd == i2cme_pkg::CMD_START) eng_sda = 1'b0;
            if (eng_cmd == i2cme_pkg::CMD_READ) eng_rx = eng_shift;
          end
        end
      end
    end
    r.rx   = eng_rx;
    r.nack = eng_nack;
    return r;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    tick_mismatches++;
    if (tick_mismatches <= MAX_REPORTS)
      $display("beat mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
  endfunction

  function automatic bit sda_pick(int sel);
    if (sel == SDA_LOW) return 1'b0;
    if (sel == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // output side: stall driver and per-field compare
  initial begin
    bus_tick_t   want;
    logic        got;
    logic [15:0] got_data;
    logic        got_done;
    m_tready = 1'b0;
    got      = 1'b0;
    got_data = '0;
    got_done = 1'b0;
    forever begin
      @(negedge clk);
      if (got) begin
        if (bus_ticks_due.size() == 0) begin
          note_mismatch("unexpected beat", 0, got_data);
        end else begin
          want = bus_ticks_due.pop_front();
          if (got_data[0] !== want.scl) note_mismatch("scl_out", want.scl, got_data[0]);
          if (got_data[1] !== want.sda_rel)
            note_mismatch("sda_release", want.sda_rel, got_data[1]);
          if (got_data[2] !== want.busy) note_mismatch("busy", want.busy, got_data[2]);
          if (got_data[10:3] !== want.rx) note_mismatch("rx_byte", want.rx, got_data[10:3]);
          if (got_data[11] !== want.nack) note_mismatch("nack_seen", want.nack, got_data[11]);
          if (got_data[15:12] !== 4'h0) note_mismatch("tdata pad", 0, got_data[15:12]);
          if (got_done !== want.done) note_mismatch("done (tlast)", want.done, got_done);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      @(posedge clk);
      got      = !rst && m_tvalid && m_tready;
      got_data = m_tdata;
      got_done = m_tlast;
    end
  end

  // Sends one tick beat; entered and left at a falling edge.
  task automatic send_tick(bit cv, i2cme_pkg::cmd_t md, logic [7:0] tx, bit nk, bit sda_in);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cv;
    s_tdata  <= {4'h0, sda_in, nk, tx, md};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bus_ticks_due.push_back(advance_engine(cv, md, tx, nk, sda_in));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic idle_ticks(int n);
    repeat (n)
      send_tick(1'b0, i2cme_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                1'($urandom));
  endtask

  // Issues a command on an idle engine and ticks it to completion; junk_pct of
  // the busy ticks carry a stray command that must be ignored.
  task automatic run_command(i2cme_pkg::cmd_t md, logic [7:0] tx, bit nk, int sda_sel,
                             int junk_pct);
    send_tick(1'b1, md, tx, nk, sda_pick(sda_sel));
    while (eng_busy)
      send_tick($urandom_range(0, 99) < junk_pct, i2cme_pkg::cmd_t'($urandom_range(0, 3)),
                8'($urandom), 1'($urandom), sda_pick(sda_sel));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (bus_ticks_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_unit_ticks(logic [7:0] value);
    while (eng_busy) idle_ticks(1);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    eng_unit_ticks = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed START/addr/data/STOP transfers, some stray commands.
  task automatic random_transfer();
    int k;
    int n;
    bit rd;
    if ($urandom_range(0, 99) < 85) begin
      run_command(i2cme_pkg::CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 20);
      idle_ticks($urandom_range(0, 2));
      run_command(i2cme_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 20);
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        idle_ticks($urandom_range(0, 2));
        rd = 1'($urandom_range(0, 1));
        run_command(rd ? i2cme_pkg::CMD_READ : i2cme_pkg::CMD_WRITE, 8'($urandom),
                    1'($urandom), SDA_RANDOM, 20);
      end
      idle_ticks($urandom_range(0, 2));
      run_command(i2cme_pkg::CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 20);
    end else if ($urandom_range(0, 1) == 1) begin
      run_command(i2cme_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                  SDA_RANDOM, 50);
    end else begin
      idle_ticks($urandom_range(1, 6));
    end
  endtask

  task automatic test_reset_unit_ticks();
    idle_ticks(3);
    run_command(i2cme_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_command(i2cme_pkg::CMD_WRITE, 8'h3C, 1'b0, SDA_RANDOM, 0);
    run_command(i2cme_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
  endtask

  task automatic test_directed_commands();
    run_command(i2cme_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_command(i2cme_pkg::CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);
    run_command(i2cme_pkg::CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 0);
    run_command(i2cme_pkg::CMD_READ, 8'hFF, 1'b0, SDA_HIGH, 0);
    run_command(i2cme_pkg::CMD_READ, 8'h00, 1'b1, SDA_LOW, 0);
    run_command(i2cme_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
    idle_ticks(2);
    // every busy tick offers another command
    run_command(i2cme_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 100);
    run_command(i2cme_pkg::CMD_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 100);
    run_command(i2cme_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 100);
    idle_ticks(2);
  endtask

  task automatic test_zero_unit_ticks();
    run_command(i2cme_pkg::CMD_START, 8'($urandom), 1'b0, SDA_RANDOM, 10);
    run_command(i2cme_pkg::CMD_WRITE, 8'($urandom), 1'b0, SDA_RANDOM, 10);
    run_command(i2cme_pkg::CMD_READ, 8'($urandom), 1'b1, SDA_RANDOM, 10);
    run_command(i2cme_pkg::CMD_STOP, 8'($urandom), 1'b0, SDA_RANDOM, 10);
  endtask

  task automatic test_random_traffic(int target);
    int start_count;
    start_count = ticks_sent;
    while (ticks_sent - start_count < target) random_transfer();
  endtask

  task automatic test_pause_until_drained();
    random_transfer();
    wait_drained();
    random_transfer();
  endtask

  task automatic test_long_unit_ticks();
    run_command(i2cme_pkg::CMD_START, 8'($urandom), 1'b0, SDA_RANDOM, 5);
    run_command(i2cme_pkg::CMD_WRITE, 8'($urandom), 1'b0, SDA_RANDOM, 5);
    run_command(i2cme_pkg::CMD_READ, 8'($urandom), 1'b1, SDA_RANDOM, 5);
    run_command(i2cme_pkg::CMD_STOP, 8'($urandom), 1'b0, SDA_RANDOM, 5);
  endtask

  initial begin
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    s_tuser         = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    tick_mismatches = 0;
    ticks_sent      = 0;
    src_gap_pct     = 19;
    sink_stall_pct  = 65;
    engine_reset();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_reset_unit_ticks();
    set_unit_ticks(8'd1);
    test_directed_commands();
    set_unit_ticks(8'd0);
    test_zero_unit_ticks();
    set_unit_ticks(8'd1);
    test_random_traffic(200);
    test_pause_until_drained();

    src_gap_pct    = 65;
    sink_stall_pct = 19;
    set_unit_ticks(8'd2);
    test_random_traffic(150);

    src_gap_pct    = 0;
    sink_stall_pct = 0;
    set_unit_ticks(8'd1);
    test_random_traffic(150);
    set_unit_ticks(8'd5);
    test_long_unit_ticks();

    wait_drained();
    repeat (16) @(negedge clk);
    @(posedge clk);
    if (tick_mismatches == 0 && bus_ticks_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
